### rtl/core/wqr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wqr_pkg
// Shared types and constants of the wait queue with removal.
// ----------------------------------------------------------------------------
package wqr_pkg;

  localparam int ID_W   = 5;
  localparam int MODE_W = 3;
  localparam int CNT_W  = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_POP    = 3'd2,
    MODE_DRAIN  = 3'd3,
    MODE_STATUS = 3'd4
  } wqr_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ISSUE
  } wqr_state_e;

  typedef struct packed {
    logic             last;
    logic [ID_W-1:0]  head_id;
    logic             queue_empty;
    logic [CNT_W-1:0] queue_count;
    logic             status;
    logic [ID_W-1:0]  taken_id;
    logic             taken_valid;
  } wqr_result_t;

endpackage
`default_nettype wire

### rtl/core/wqr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wqr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wqr_ram #(
  parameter int W     = 5,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/wqr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wqr_ctrl
// Request sequencer: reads the link memories, relinks neighbours, keeps
// head, tail, count and the queued bits, and builds each result.
// ----------------------------------------------------------------------------
module wqr_ctrl #(
  parameter int SLOTS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_valid_i,
  output logic                          s_ready_o,
  input  wire logic [wqr_pkg::MODE_W-1:0] mode_i,
  input  wire logic [wqr_pkg::ID_W-1:0] slot_i,
  output logic                          nx_we_o,
  output logic [$clog2(SLOTS)-1:0]      nx_waddr_o,
  output logic [$clog2(SLOTS)-1:0]      nx_wdata_o,
  output logic                          pv_we_o,
  output logic [$clog2(SLOTS)-1:0]      pv_waddr_o,
  output logic [$clog2(SLOTS)-1:0]      pv_wdata_o,
  output logic                          re_o,
  output logic [$clog2(SLOTS)-1:0]      raddr_o,
  input  wire logic [$clog2(SLOTS)-1:0] rd_next_i,
  input  wire logic [$clog2(SLOTS)-1:0] rd_prev_i,
  output logic                          res_valid_o,
  output wqr_pkg::wqr_result_t          res_o,
  input  wire logic                     out_free_i
);
  import wqr_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  function automatic logic [IW-1:0] to_idx(logic [ID_W-1:0] v);
    logic [IW+ID_W-1:0] w;
    w = {{IW{1'b0}}, v};
    return w[IW-1:0];
  endfunction

  function automatic logic [ID_W-1:0] to_id(logic [IW-1:0] v);
    logic [IW+ID_W-1:0] w;
    w = {{ID_W{1'b0}}, v};
    return w[ID_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] to_cnt(logic [CW-1:0] v);
    logic [CW+CNT_W-1:0] w;
    w = {{CNT_W{1'b0}}, v};
    return w[CNT_W-1:0];
  endfunction

  wqr_state_e       state_q, state_d;
  wqr_mode_e        mode_q, mode_d;
  logic [IW-1:0]    sidx_q, sidx_d;
  logic             rng_q, rng_d;
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [SLOTS-1:0] queued_q, queued_d;

  wqr_mode_e        in_mode;
  logic [IW-1:0]    in_idx;
  logic             in_rng;
  logic             acc;
  logic             ok;
  logic             taken;
  logic             do_unlink;
  logic [IW-1:0]    u_idx;

  assign in_mode   = wqr_mode_e'(mode_i);
  assign in_idx    = to_idx(slot_i);
  assign in_rng    = (32'(slot_i) < 32'(SLOTS));
  assign s_ready_o = (state_q == ST_IDLE);
  assign acc       = s_valid_i && s_ready_o;
  assign u_idx     = (mode_q == MODE_REMOVE) ? sidx_q : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      queued_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      queued_q <= queued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    sidx_q <= sidx_d;
    rng_q  <= rng_d;
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    sidx_d      = sidx_q;
    rng_d       = rng_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    queued_d    = queued_q;
    nx_we_o     = 1'b0;
    nx_waddr_o  = '0;
    nx_wdata_o  = '0;
    pv_we_o     = 1'b0;
    pv_waddr_o  = '0;
    pv_wdata_o  = '0;
    re_o        = 1'b0;
    raddr_o     = head_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    ok          = 1'b0;
    taken       = 1'b0;
    do_unlink   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          mode_d  = in_mode;
          sidx_d  = in_idx;
          rng_d   = in_rng;
          state_d = ST_EXEC;
          re_o    = (in_mode == MODE_REMOVE) || (in_mode == MODE_POP) ||
                    (in_mode == MODE_DRAIN);
          raddr_o = (in_mode == MODE_REMOVE) ? in_idx : head_q;
          // own links of the new slot are written at accept
          if ((in_mode == MODE_PUSH) && in_rng && !queued_q[in_idx]) begin
            nx_we_o    = 1'b1;
            nx_waddr_o = in_idx;
            nx_wdata_o = (cnt_q == '0) ? in_idx : head_q;
            pv_we_o    = 1'b1;
            pv_waddr_o = in_idx;
            pv_wdata_o = (cnt_q == '0) ? in_idx : tail_q;
          end
        end
      end

      ST_ISSUE: begin
        re_o    = 1'b1;
        raddr_o = head_q;
        state_d = ST_EXEC;
      end

      ST_EXEC: begin
        if (out_free_i) begin
          case (mode_q)
            MODE_PUSH: begin
              ok = rng_q && !queued_q[sidx_q];
              if (ok) begin
                queued_d[sidx_q] = 1'b1;
                cnt_d            = cnt_q + CW'(1);
                tail_d           = sidx_q;
                if (cnt_q == '0) begin
                  head_d = sidx_q;
                end else begin
                  nx_we_o    = 1'b1;
                  nx_waddr_o = tail_q;
                  nx_wdata_o = sidx_q;
                  pv_we_o    = 1'b1;
                  pv_waddr_o = head_q;
                  pv_wdata_o = sidx_q;
                end
              end
            end
            MODE_REMOVE: begin
              ok        = rng_q && queued_q[sidx_q] && (cnt_q != '0);
              do_unlink = ok;
            end
            MODE_POP, MODE_DRAIN: begin
              ok        = (cnt_q != '0);
              do_unlink = ok;
              taken     = ok;
            end
            default: begin
              ok = 1'b1;
            end
          endcase

          if (do_unlink) begin
            queued_d[u_idx] = 1'b0;
            if ((rd_next_i == u_idx) || (cnt_q <= CW'(1))) begin
              head_d = '0;
              cnt_d  = '0;
            end else begin
              nx_we_o    = 1'b1;
              nx_waddr_o = rd_prev_i;
              nx_wdata_o = rd_next_i;
              pv_we_o    = 1'b1;
              pv_waddr_o = rd_next_i;
              pv_wdata_o = rd_prev_i;
              if (head_q == u_idx) head_d = rd_next_i;
              if (tail_q == u_idx) tail_d = rd_prev_i;
              cnt_d = cnt_q - CW'(1);
            end
          end

          res_valid_o       = 1'b1;
          res_o.taken_valid = taken;
          res_o.taken_id    = taken ? to_id(u_idx) : '0;
          res_o.status      = !ok;
          res_o.queue_count = to_cnt(cnt_d);
          res_o.queue_empty = (cnt_d == '0);
          res_o.head_id     = (cnt_d == '0) ? '0 : to_id(head_d);

          if ((mode_q == MODE_DRAIN) && ok && (cnt_d != '0)) begin
            res_o.last = 1'b0;
            state_d    = ST_ISSUE;
          end else begin
            res_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_count_matches_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(queued_q) == 32'(cnt_q))
    else $error("queued bits disagree with count");

  a_head_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> queued_q[head_q])
    else $error("head slot not queued");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result produced into a full output register");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == ST_EXEC))
    else $error("accepted request not executed");

  a_drain_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> (state_q == ST_ISSUE))
    else $error("drain stopped before its last result");

endmodule
`default_nettype wire

### rtl/core/wqr_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wqr_out_reg
// Output register of the result stream, decoupling the sequencer from stalls.
// ----------------------------------------------------------------------------
module wqr_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire wqr_pkg::wqr_result_t res_i,
  output logic                      free_o,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [23:0]               m_axis_tdata,
  output logic                      m_axis_tlast
);
  import wqr_pkg::*;

  logic        valid_q, valid_d;
  wqr_result_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'b0, res_q.head_id, res_q.queue_empty, res_q.queue_count,
                          res_q.status, res_q.taken_id, res_q.taken_valid};
  assign m_axis_tlast  = res_q.last;

endmodule
`default_nettype wire

### rtl/core/wait_queue_with_removal_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Push/remove/pop/status: the execute state loads the result once the output is free.
// Requests: a link memory read, then a relink write; accepted only when idle.
// Drain: one result per slot taken; an issue state rereads the head between slots.
// Reset: queue empty, queued bits cleared at once; link memories are not
// cleared; their contents are only used for queued slots, so no clearing is needed.
// ----------------------------------------------------------------------------
// wait_queue_with_removal_unit
// FIFO wait queue of task slots kept as a circular doubly linked list in two
// link memories, with push, arbitrary remove, pop, drain and status requests.
// ----------------------------------------------------------------------------
module wait_queue_with_removal_unit #(
  parameter int SLOTS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [4:0] slot_id
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [0] taken_valid, [5:1] taken_id,
                                          // [6] status, [12:7] queue_count,
                                          // [13] queue_empty, [18:14] head_id
  output logic             m_axis_tlast
);
  import wqr_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic          nx_we, pv_we, re;
  logic [IW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata, raddr;
  logic [IW-1:0] rd_next, rd_prev;
  logic          res_valid, out_free;
  wqr_result_t   res;

  wqr_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .slot_i     (s_axis_tdata[ID_W-1:0]),
    .nx_we_o    (nx_we),
    .nx_waddr_o (nx_waddr),
    .nx_wdata_o (nx_wdata),
    .pv_we_o    (pv_we),
    .pv_waddr_o (pv_waddr),
    .pv_wdata_o (pv_wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rd_next_i  (rd_next),
    .rd_prev_i  (rd_prev),
    .res_valid_o(res_valid),
    .res_o      (res),
    .out_free_i (out_free)
  );

  wqr_ram #(
    .W    (IW),
    .DEPTH(SLOTS)
  ) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (nx_we),
    .waddr_i(nx_waddr),
    .wdata_i(nx_wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_next)
  );

  wqr_ram #(
    .W    (IW),
    .DEPTH(SLOTS)
  ) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (pv_we),
    .waddr_i(pv_waddr),
    .wdata_i(pv_wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_prev)
  );

  wqr_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (res_valid),
    .res_i        (res),
    .free_o       (out_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
`default_nettype wire
